/* sv/kmau_pkg.sv */
// ----------------------------------------------------------------------------
// kmau_pkg
// Shared types and constants for the 2-D k-means assign and update block.
// ----------------------------------------------------------------------------
package kmau_pkg;

    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_MAX_POINTS   = 65536;
    localparam int DEF_COORD_WIDTH  = 16;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ASSIGN = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [0:0] REG_CLUSTER_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_ASSIGN_OUT,
        ST_UPD_DIV,
        ST_UPD_WAIT,
        ST_UPD_OUT,
        ST_CLEAR
    } t_state;

    // One queued command from the front end.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0]  prior;
        logic [3:0]  idx;
    } t_cmd;

endpackage

/* sv/kmau_front.sv */
// ----------------------------------------------------------------------------
// kmau_front
// Accepts items and queues load, assign and update commands, in order, for
// the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module kmau_front import kmau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_coord_x,
    input  logic [15:0] i_coord_y,
    input  logic [4:0]  i_prior_cluster,
    input  logic [3:0]  i_load_index,
    input  logic        i_pop,
    output logic        o_busy,
    output logic        o_q_valid,
    output t_cmd        o_q_head
);
    t_cmd       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       acc, push;

    assign o_busy     = (r_cnt == 2'd2);
    assign acc        = i_start && !o_busy;
    assign push       = acc && (i_mode != MODE_UNUSED);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_head   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
        if (push) r_q[r_wr] <= '{mode: i_mode, x: i_coord_x, y: i_coord_y,
                                 prior: i_prior_cluster, idx: i_load_index};
    end
endmodule

/* sv/kmau_back.sv */
// ----------------------------------------------------------------------------
// kmau_back
// Executes queued commands: centroid loads, one distance per cycle for
// assignment, and one shared bit-serial signed divider for the update pass.
// ----------------------------------------------------------------------------
module kmau_back import kmau_pkg::*; #(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_cluster_count,
    input  logic        i_q_valid,
    input  t_cmd        i_q_head,
    output logic        o_pop,
    output logic        o_idle,
    output logic        o_valid,
    output logic        o_kind,
    output logic [3:0]  o_assigned_cluster,
    output logic        o_moved,
    output logic [3:0]  o_centroid_slot,
    output logic [15:0] o_mean_x,
    output logic [15:0] o_mean_y,
    output logic [16:0] o_moves_in_pass,
    output logic        o_last
);
    localparam int NC  = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;
    localparam int PTW = $clog2(MAX_POINTS + 1);

    logic signed [15:0] r_cx [16];
    logic signed [15:0] r_cy [16];
    logic signed [31:0] r_sx [16];
    logic signed [31:0] r_sy [16];
    logic [PTW-1:0]     r_cnt [16];
    logic [PTW-1:0]     r_mv;

    t_state r_st, n_st;
    logic [3:0]  r_k, n_k, r_best, n_best;
    logic [32:0] r_bd, n_bd;
    logic [5:0]  r_bit, n_bit;
    logic [31:0] r_qx, r_qy, n_qx, n_qy;
    logic [PTW:0] r_rx, r_ry, n_rx, n_ry;

    logic [4:0] nuse;
    logic [3:0] klast;
    always_comb begin
        nuse = (i_cluster_count == 5'd0) ? 5'd1 : i_cluster_count;
        if (nuse > 5'(NC)) nuse = 5'(NC);
        klast = 4'(nuse - 5'd1);
    end

    // A load at the queue head is carried out while the back end is idle and is popped in the same cycle.
    logic load_we;
    assign load_we = (r_st == ST_IDLE) && i_q_valid && (i_q_head.mode == MODE_LOAD);

    // Distance to centroid r_k.
    logic signed [16:0] dx, dy;
    logic [16:0] ax, ay;
    logic [32:0] sq_dist;
    always_comb begin
        dx   = $signed({i_q_head.x[15], i_q_head.x}) - $signed({r_cx[r_k][15], r_cx[r_k]});
        dy   = $signed({i_q_head.y[15], i_q_head.y}) - $signed({r_cy[r_k][15], r_cy[r_k]});
        ax   = dx[16] ? 17'(-dx) : 17'(dx);
        ay   = dy[16] ? 17'(-dy) : 17'(dy);
        sq_dist = 33'(34'(ax * ax) + 34'(ay * ay));
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    logic [31:0] mx, my;
    logic [PTW:0] tx, ty;
    logic         empty;
    assign mx    = r_sx[r_k][31] ? 32'(-r_sx[r_k]) : r_sx[r_k];
    assign my    = r_sy[r_k][31] ? 32'(-r_sy[r_k]) : r_sy[r_k];
    assign tx    = {r_rx[PTW-1:0], mx[5'(r_bit)]};
    assign ty    = {r_ry[PTW-1:0], my[5'(r_bit)]};
    assign empty = (r_cnt[r_k] == '0);

    logic [31:0] qxs, qys;
    assign qxs = r_sx[r_k][31] ? 32'(-r_qx) : r_qx;
    assign qys = r_sy[r_k][31] ? 32'(-r_qy) : r_qy;

    logic moved;
    assign moved = ($signed(i_q_head.prior) != $signed({1'b0, r_best}));

    always_comb begin
        n_st = r_st; n_k = r_k; n_best = r_best; n_bd = r_bd;
        n_bit = r_bit; n_qx = r_qx; n_qy = r_qy; n_rx = r_rx; n_ry = r_ry;
        o_pop = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                n_k = 4'd0;
                if (i_q_valid) begin
                    if (i_q_head.mode == MODE_LOAD) o_pop = 1'b1;
                    else if (i_q_head.mode == MODE_ASSIGN) n_st = ST_DIST;
                    else begin
                        n_st = ST_UPD_DIV; n_bit = 6'd31;
                        n_qx = '0; n_qy = '0; n_rx = '0; n_ry = '0;
                    end
                end
            end
            ST_DIST: begin
                if (r_k == 4'd0 || sq_dist < r_bd) begin
                    n_best = r_k; n_bd = sq_dist;
                end
                if (r_k == klast) n_st = ST_ASSIGN_OUT;
                else n_k = r_k + 4'd1;
            end
            ST_ASSIGN_OUT: begin
                o_pop = 1'b1; n_st = ST_IDLE;
            end
            ST_UPD_DIV: begin
                if (tx >= {1'b0, r_cnt[r_k]}) begin
                    n_rx = tx - {1'b0, r_cnt[r_k]}; n_qx = {r_qx[30:0], 1'b1};
                end else begin
                    n_rx = tx; n_qx = {r_qx[30:0], 1'b0};
                end
                if (ty >= {1'b0, r_cnt[r_k]}) begin
                    n_ry = ty - {1'b0, r_cnt[r_k]}; n_qy = {r_qy[30:0], 1'b1};
                end else begin
                    n_ry = ty; n_qy = {r_qy[30:0], 1'b0};
                end
                if (empty || r_bit == 6'd0) n_st = ST_UPD_WAIT;
                else n_bit = r_bit - 6'd1;
            end
            ST_UPD_WAIT: n_st = ST_UPD_OUT;
            ST_UPD_OUT: begin
                n_bit = 6'd31; n_qx = '0; n_qy = '0; n_rx = '0; n_ry = '0;
                if (r_k == klast) n_st = ST_CLEAR;
                else begin
                    n_k = r_k + 4'd1; n_st = ST_UPD_DIV;
                end
            end
            ST_CLEAR: begin
                o_pop = 1'b1; n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_idle = (r_st == ST_IDLE) && !i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_mv <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_cx[i] <= '0; r_cy[i] <= '0;
                r_sx[i] <= '0; r_sy[i] <= '0; r_cnt[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            o_valid <= 1'b0;
            if (load_we && 32'(i_q_head.idx) < MAX_CLUSTERS) begin
                r_cx[i_q_head.idx] <= i_q_head.x;
                r_cy[i_q_head.idx] <= i_q_head.y;
            end
            if (r_st == ST_ASSIGN_OUT) begin
                o_valid <= 1'b1;
                if (moved && 32'(r_mv) < MAX_POINTS) r_mv <= r_mv + PTW'(1);
                if (32'(r_cnt[r_best]) < MAX_POINTS) begin
                    r_sx[r_best]  <= r_sx[r_best] + 32'($signed(i_q_head.x));
                    r_sy[r_best]  <= r_sy[r_best] + 32'($signed(i_q_head.y));
                    r_cnt[r_best] <= r_cnt[r_best] + PTW'(1);
                end
            end
            if (r_st == ST_UPD_WAIT && !empty) begin
                r_cx[r_k] <= qxs[15:0];
                r_cy[r_k] <= qys[15:0];
            end
            if (r_st == ST_UPD_OUT) o_valid <= 1'b1;
            if (r_st == ST_CLEAR) begin
                r_mv <= '0;
                for (int i = 0; i < 16; i++) begin
                    r_sx[i] <= '0; r_sy[i] <= '0; r_cnt[i] <= '0;
                end
            end
        end
        r_k <= n_k; r_best <= n_best; r_bd <= n_bd; r_bit <= n_bit;
        r_qx <= n_qx; r_qy <= n_qy; r_rx <= n_rx; r_ry <= n_ry;
        o_kind             <= (r_st == ST_UPD_OUT);
        o_assigned_cluster <= (r_st == ST_ASSIGN_OUT) ? r_best : 4'd0;
        o_moved            <= (r_st == ST_ASSIGN_OUT) && moved;
        o_centroid_slot    <= (r_st == ST_UPD_OUT) ? r_k : 4'd0;
        o_mean_x           <= (r_st == ST_UPD_OUT) ? r_cx[r_k] : 16'd0;
        o_mean_y           <= (r_st == ST_UPD_OUT) ? r_cy[r_k] : 16'd0;
        o_moves_in_pass    <= (r_st == ST_UPD_OUT) ? 17'(r_mv) : 17'd0;
        o_last             <= (r_st == ST_UPD_OUT) && (r_k == klast);
    end
endmodule

/* sv/kmeans_assign_and_update_2d_core.sv */
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_2d_core
// One Lloyd k-means pass on 2-D signed fixed-point points.
// ----------------------------------------------------------------------------
// Usage: drive an item with i_start while o_busy is low. Load, assign and
// update items enter a two-entry command queue and are carried out in order;
// mode 3 is dropped at the input. A load writes a centroid and gives no word.
// An assign gives one word (o_kind 0) with the nearest cluster and a moved
// flag; an update gives one word per cluster in use (o_kind 1) with the new
// mean, the final one marked o_last. Each word is on the result ports for one
// cycle, marked by o_valid.
// An assign word appears once the single distance unit has visited each of
// the clusters in use, one centroid per cycle; the back end is then free
// again. An update runs the bit-serial divider, one quotient bit a cycle, on
// each cluster in turn and gives that cluster's word after its division; an
// empty cluster stops the division at once and keeps its centroid. A load is
// carried out in the idle state. o_busy rises only when the queue is full.
// The receiver cannot stall.
// Reset (synchronous, active low) clears centroids, sums, counts and the
// move counter and sets cluster_count to one. cluster_count lives at APB
// address 0 and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_2d_core import kmau_pkg::*; #(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_coord_x,
    input  logic [15:0] i_coord_y,
    input  logic [4:0]  i_prior_cluster,
    input  logic [3:0]  i_load_index,
    output logic        o_valid,
    output logic        o_kind,
    output logic [3:0]  o_assigned_cluster,
    output logic        o_moved,
    output logic [3:0]  o_centroid_slot,
    output logic [15:0] o_mean_x,
    output logic [15:0] o_mean_y,
    output logic [16:0] o_moves_in_pass,
    output logic        o_last
);
    logic [4:0] r_cluster_count;
    logic       q_valid, pop, idle;
    t_cmd       q_head;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CLUSTER_COUNT) ? {27'd0, r_cluster_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cluster_count <= 5'd1;
        else if (psel && penable && pwrite && paddr == REG_CLUSTER_COUNT)
            r_cluster_count <= pwdata[4:0];
    end

    kmau_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_mode, .i_coord_x, .i_coord_y,
        .i_prior_cluster, .i_load_index, .i_pop(pop), .o_busy,
        .o_q_valid(q_valid), .o_q_head(q_head)
    );

    kmau_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk, .i_rst_n, .i_cluster_count(r_cluster_count),
        .i_q_valid(q_valid), .i_q_head(q_head),
        .o_pop(pop), .o_idle(idle), .o_valid, .o_kind, .o_assigned_cluster,
        .o_moved, .o_centroid_slot, .o_mean_x, .o_mean_y, .o_moves_in_pass,
        .o_last
    );

    a_last_is_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind) else $error("last set on assign word");
    a_no_word_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(idle) && idle |-> !o_valid) else $error("word while idle");
    a_assign_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_moves_in_pass == 17'd0) else $error("assign word dirty");
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the 2-D k-means block: centroid loads, point assignment and
// pass updates are driven through the command port, cluster_count through
// the APB port, and every result word is compared with a software predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import kmau_pkg::*;

    localparam int WATCHDOG = 20000;

    typedef struct {
        logic        kind;
        logic [3:0]  cluster;
        logic        moved;
        logic [3:0]  slot;
        logic [15:0] mx;
        logic [15:0] my;
        logic [16:0] moves;
        logic        last;
    } t_word;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0]  prior;
        logic [3:0]  idx;
        logic        has_exp;
        logic [3:0]  exp_cluster;
        logic        exp_moved;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_mode;
    logic [15:0] i_coord_x, i_coord_y;
    logic [4:0]  i_prior_cluster;
    logic [3:0]  i_load_index;
    logic        o_valid, o_kind, o_moved, o_last;
    logic [3:0]  o_assigned_cluster, o_centroid_slot;
    logic [15:0] o_mean_x, o_mean_y;
    logic [16:0] o_moves_in_pass;

    kmeans_assign_and_update_2d_core u_top (.*);

    // Predictor state.
    logic signed [15:0] cen_x [16];
    logic signed [15:0] cen_y [16];
    longint             acc_x [16];
    longint             acc_y [16];
    int                 members [16];
    int                 move_cnt;
    logic [4:0]         k_reg;

    t_word expected_words [$];
    int    errors;
    int    idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int used_clusters();
        if (k_reg == 0) return 1;
        if (k_reg > 16) return 16;
        return int'(k_reg);
    endfunction

    // Applies one command to the model and queues the words it produces.
    task automatic predict_command(input t_row r);
        t_word w;
        int best, n;
        longint bd, d, dx, dy;
        n = used_clusters();
        w = '{default: '0};
        case (r.mode)
            MODE_LOAD: begin
                cen_x[r.idx] = r.x;
                cen_y[r.idx] = r.y;
            end
            MODE_ASSIGN: begin
                best = 0;
                bd = 0;
                for (int k = 0; k < n; k++) begin
                    dx = longint'($signed(r.x)) - cen_x[k];
                    dy = longint'($signed(r.y)) - cen_y[k];
                    d = dx * dx + dy * dy;
                    if (k == 0 || d < bd) begin
                        best = k;
                        bd = d;
                    end
                end
                w.cluster = 4'(best);
                w.moved = (int'($signed(r.prior)) != best);
                if (w.moved && move_cnt < DEF_MAX_POINTS) move_cnt++;
                if (members[best] < DEF_MAX_POINTS) begin
                    acc_x[best] += $signed(r.x);
                    acc_y[best] += $signed(r.y);
                    members[best]++;
                end
                expected_words.push_back(w);
            end
            MODE_UPDATE: begin
                for (int k = 0; k < n; k++) begin
                    if (members[k] != 0) begin
                        cen_x[k] = 16'(acc_x[k] / members[k]);
                        cen_y[k] = 16'(acc_y[k] / members[k]);
                    end
                    w = '{default: '0};
                    w.kind = 1'b1;
                    w.slot = 4'(k);
                    w.mx = cen_x[k];
                    w.my = cen_y[k];
                    w.moves = 17'(move_cnt);
                    w.last = (k == n - 1);
                    expected_words.push_back(w);
                end
                for (int k = 0; k < 16; k++) begin
                    acc_x[k] = 0;
                    acc_y[k] = 0;
                    members[k] = 0;
                end
                move_cnt = 0;
            end
            default: ;
        endcase
    endtask

    // Drives one item and returns just after the edge that accepts it;
    // i_start stays high so that the next item may follow with no gap.
    task automatic send_command(input t_row r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_mode <= r.mode;
        i_coord_x <= r.x;
        i_coord_y <= r.y;
        i_prior_cluster <= r.prior;
        i_load_index <= r.idx;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_command(r);
        if (r.has_exp) begin
            expected_words[$].cluster = r.exp_cluster;
            expected_words[$].moved = r.exp_moved;
        end
    endtask

    task automatic release_start();
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic drain();
        release_start();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (40 * 16) @(negedge i_clk);
    endtask

    task automatic write_cluster_count(input logic [4:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_CLUSTER_COUNT;
        pwdata <= {27'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        k_reg = v;
    endtask

    function automatic t_row mk(input logic [1:0] m, input logic [15:0] x,
                                input logic [15:0] y, input logic [4:0] p,
                                input logic [3:0] i);
        t_row r;
        r = '{default: '0};
        r.mode = m;
        r.x = x;
        r.y = y;
        r.prior = p;
        r.idx = i;
        return r;
    endfunction

    // Random coordinates: extremes now and then, small values near zero, otherwise spread values.
    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_word e;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: expected no word, actual word kind=%0d", $time, o_kind);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_kind !== e.kind || o_assigned_cluster !== e.cluster ||
                    o_moved !== e.moved || o_centroid_slot !== e.slot ||
                    o_mean_x !== e.mx || o_mean_y !== e.my ||
                    o_moves_in_pass !== e.moves || o_last !== e.last) begin
                    $display("%0t: expected k%0d c%0d m%0d s%0d x%h y%h n%0d l%0d",
                             $time, e.kind, e.cluster, e.moved, e.slot, e.mx, e.my,
                             e.moves, e.last);
                    $display("%0t: actual   k%0d c%0d m%0d s%0d x%h y%h n%0d l%0d",
                             $time, o_kind, o_assigned_cluster, o_moved,
                             o_centroid_slot, o_mean_x, o_mean_y, o_moves_in_pass,
                             o_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word in either direction.
    always @(posedge i_clk) begin
        if (o_valid || (i_start && !o_busy) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row dir [$];
        t_row r;
        int n;
        errors = 0;
        idle_cycles = 0;
        move_cnt = 0;
        k_reg = 5'd1;
        for (int k = 0; k < 16; k++) begin
            cen_x[k] = 0; cen_y[k] = 0; acc_x[k] = 0; acc_y[k] = 0; members[k] = 0;
        end
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_start = 1'b0; i_mode = MODE_LOAD; i_coord_x = '0; i_coord_y = '0;
        i_prior_cluster = '0; i_load_index = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset one cluster at the origin: every point goes to cluster 0.
        r = mk(MODE_ASSIGN, 16'h8000, 16'h8000, 5'h1f, '0);
        r.has_exp = 1; r.exp_cluster = 0; r.exp_moved = 1;
        dir.push_back(r);
        r = mk(MODE_ASSIGN, 16'h7fff, 16'h7fff, 5'd0, '0);
        r.has_exp = 1; r.exp_cluster = 0; r.exp_moved = 0;
        dir.push_back(r);
        dir.push_back(mk(MODE_UPDATE, '0, '0, '0, '0));
        dir.push_back(mk(MODE_UNUSED, 16'h1234, 16'h4321, '0, '0));
        foreach (dir[i]) send_command(dir[i]);
        drain();

        write_cluster_count(5'd16);
        dir.delete();
        // Ties between equal centroids, empty clusters and signed truncation.
        dir.push_back(mk(MODE_LOAD, 16'h0010, 16'h0010, '0, 4'd3));
        dir.push_back(mk(MODE_LOAD, 16'h0010, 16'h0010, '0, 4'd5));
        dir.push_back(mk(MODE_LOAD, 16'h8000, 16'h8000, '0, 4'd15));
        dir.push_back(mk(MODE_LOAD, 16'h7fff, 16'h8000, '0, 4'd7));
        dir.push_back(mk(MODE_ASSIGN, 16'h0010, 16'h0010, 5'd5, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'h8000, 16'h8000, 5'd15, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'h8001, 16'h8000, 5'd2, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'h7fff, 16'h8001, 5'd7, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'hfffd, 16'h0002, 5'h10, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'hfffe, 16'h0001, 5'd0, '0));
        dir.push_back(mk(MODE_UPDATE, '0, '0, '0, '0));
        dir.push_back(mk(MODE_ASSIGN, 16'h5555, 16'haaaa, 5'h0a, '0));
        dir.push_back(mk(MODE_UPDATE, '0, '0, '0, '0));
        foreach (dir[i]) send_command(dir[i]);
        drain();

        // Out-of-range count settings act as one and as sixteen.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cluster_count(5'd0);
                1: write_cluster_count(5'd31);
                2: write_cluster_count(5'd2);
                default: write_cluster_count(5'($urandom_range(1, 16)));
            endcase
            n = used_clusters();
            for (int p = 0; p < 2; p++) begin
                // A pass: loads, a run of assigns, then an update.
                for (int k = 0; k < n; k++)
                    if ($urandom_range(0, 2) != 0)
                        send_command(mk(MODE_LOAD, rnd_coord(), rnd_coord(), '0, 4'(k)));
                for (int j = 0; j < 15; j++) begin
                    r = mk(MODE_ASSIGN, rnd_coord(), rnd_coord(),
                           $urandom_range(0, 3) == 0 ? 5'h1f : 5'($urandom), '0);
                    if ($urandom_range(0, 7) == 0)
                        r = mk($urandom_range(0, 3) == 0 ? MODE_UNUSED : MODE_LOAD,
                               16'($urandom), 16'($urandom), 5'($urandom),
                               4'($urandom));
                    send_command(r);
                end
                send_command(mk(MODE_UPDATE, 16'($urandom), 16'($urandom),
                                5'($urandom), 4'($urandom)));
                if (p == 0) begin
                    release_start();
                    while (expected_words.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

/* kmeans_assign_and_update_2d_core.f */
sv/kmau_pkg.sv
sv/kmau_front.sv
sv/kmau_back.sv
sv/kmeans_assign_and_update_2d_core.sv
tb/sv/tb_top.sv
